@@ src/eirc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the Ethernet/IPv4 receive classifier.
// Used by ethernet_ipv4_rx_classifier; depends on nothing else.

package eirc_pkg;

    localparam int unsigned DATA_W      = 8;
    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned OFFSET_W    = 7;
    localparam int unsigned LENGTH_W    = 16;
    localparam int unsigned VERDICT_W   = 4;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned RESULT_W    = VERDICT_W + ADDR_W + OFFSET_W + LENGTH_W;
    localparam int unsigned M_TDATA_W   = ((RESULT_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0]  COUNT_MAX      = 16'hFFFF;
    localparam logic [COUNT_W-1:0]  ETH_HDR_LEN    = 16'd14;
    localparam logic [COUNT_W-1:0]  IPV4_MIN_FRAME = 16'd34;
    localparam logic [15:0]         TYPE_ARP       = 16'h0806;
    localparam logic [15:0]         TYPE_IPV4      = 16'h0800;
    localparam logic [ADDR_W-1:0]   BCAST_ADDR     = 32'hFFFF_FFFF;
    localparam logic [7:0]          PROTO_ICMP     = 8'd1;
    localparam logic [7:0]          PROTO_TCP      = 8'd6;
    localparam logic [7:0]          PROTO_UDP      = 8'd17;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_IP     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ADDR_ENABLED = 1'b1;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_SHORT        = 4'd0,
        VERDICT_ARP          = 4'd1,
        VERDICT_ICMP         = 4'd2,
        VERDICT_UDP          = 4'd3,
        VERDICT_TCP          = 4'd4,
        VERDICT_UNKNOWN_PROT = 4'd5,
        VERDICT_UNKNOWN_TYPE = 4'd6,
        VERDICT_NOT_FOR_US   = 4'd7,
        VERDICT_IPV4_SHORT   = 4'd8
    } verdict_t;

    typedef struct packed {
        logic [LENGTH_W-1:0] payload_length;
        logic [OFFSET_W-1:0] payload_offset;
        logic [ADDR_W-1:0]   source_ip;
        verdict_t            verdict;
    } result_t;

endpackage

@@ src/ethernet_ipv4_rx_classifier.sv @@
`timescale 1ns / 1ps
// Ethernet/IPv4 receive header classifier: one verdict word per received frame.
// Depends on eirc_pkg for types and constants.
//
//  Channel   Direction  Signals                                  Word content
//  --------  ---------  ---------------------------------------  ------------------------
//  s_axis    in         tvalid, tready, tdata[7:0], tlast        frame byte, end of frame
//  m_axis    out        tvalid, tready, tdata[63:0]              verdict and its fields
//  cfg       in         cfg_wr_en, cfg_addr[0:0], cfg_wdata[31:0] register writes
//
// Frame bytes are accepted while s_axis_tready is high; the header fields are captured
// and, on the last byte, the verdict is formed in the same cycle and lands in the output
// register, or in the skid register behind it when that is full and not being emptied;
// bytes flow on while a verdict waits; s_axis_tready falls only when both are full.
// Reset (rst_n, asynchronous, active low) clears the frame state, the registers and
// the output valid flags; no clearing pass is needed.

module ethernet_ipv4_rx_classifier
(
    input  logic                                clk,
    input  logic                                rst_n,

    // Frame byte stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [eirc_pkg::DATA_W-1:0]         s_axis_tdata,   // [7:0] data_byte
    input  logic                                s_axis_tlast,   // end_of_frame

    // Verdict stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [3:0] verdict, [35:4] source_ip, [42:36] payload_offset,
    // [58:43] payload_length, [63:59] zero
    output logic [eirc_pkg::M_TDATA_W-1:0]      m_axis_tdata,

    // Configuration write port.
    input  logic                                cfg_wr_en,
    input  logic [eirc_pkg::CFG_INDEX_W-1:0]    cfg_addr,
    input  logic [eirc_pkg::ADDR_W-1:0]         cfg_wdata
);

    // Configuration registers.
    logic [eirc_pkg::ADDR_W-1:0]    local_ip_reg;
    logic                           addr_enabled_reg;

    // Per-frame state.
    logic [eirc_pkg::COUNT_W-1:0]   byte_count_reg, byte_count_next;
    logic [15:0]                    ether_type_reg, ether_type_next;
    logic [3:0]                     header_words_reg, header_words_next;
    logic [15:0]                    total_length_reg, total_length_next;
    logic [7:0]                     protocol_reg, protocol_next;
    logic [eirc_pkg::ADDR_W-1:0]    source_reg, source_next;
    logic [eirc_pkg::ADDR_W-1:0]    dest_reg, dest_next;

    // Field values including the byte being accepted now.
    logic [eirc_pkg::COUNT_W-1:0]   count_cap;
    logic [15:0]                    ether_type_cap;
    logic [3:0]                     header_words_cap;
    logic [15:0]                    total_length_cap;
    logic [7:0]                     protocol_cap;
    logic [eirc_pkg::ADDR_W-1:0]    source_cap;
    logic [eirc_pkg::ADDR_W-1:0]    dest_cap;

    // Output side.
    logic                           out_valid_reg;
    logic                           skid_valid_reg;
    eirc_pkg::result_t              out_reg;
    eirc_pkg::result_t              skid_reg;
    eirc_pkg::result_t              result;

    logic                           in_fire;
    logic                           out_fire;
    logic                           produce;

    logic [5:0]                     header_len;
    logic [15:0]                    header_len_wide;

    assign s_axis_tready = !skid_valid_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = out_valid_reg && m_axis_tready;
    assign produce       = in_fire && s_axis_tlast;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(eirc_pkg::M_TDATA_W - eirc_pkg::RESULT_W){1'b0}},
                            out_reg.payload_length, out_reg.payload_offset,
                            out_reg.source_ip, out_reg.verdict};

    // Configuration writes. A write to an index outside the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg     <= '0;
            addr_enabled_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                eirc_pkg::CFG_LOCAL_IP:     local_ip_reg     <= cfg_wdata;
                eirc_pkg::CFG_ADDR_ENABLED: addr_enabled_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Header capture. The byte count is the position of the current byte; once it
    // has saturated, further bytes are neither captured nor counted.
    always_comb
    begin
        count_cap        = byte_count_reg;
        ether_type_cap   = ether_type_reg;
        header_words_cap = header_words_reg;
        total_length_cap = total_length_reg;
        protocol_cap     = protocol_reg;
        source_cap       = source_reg;
        dest_cap         = dest_reg;

        if (byte_count_reg != eirc_pkg::COUNT_MAX)
        begin
            count_cap = byte_count_reg + 16'd1;
            case (byte_count_reg) inside
                16'd12, 16'd13:
                    ether_type_cap = {ether_type_reg[7:0], s_axis_tdata};
                16'd14:
                    header_words_cap = s_axis_tdata[3:0];
                16'd16, 16'd17:
                    total_length_cap = {total_length_reg[7:0], s_axis_tdata};
                16'd23:
                    protocol_cap = s_axis_tdata;
                [16'd26:16'd29]:
                    source_cap = {source_reg[23:0], s_axis_tdata};
                [16'd30:16'd33]:
                    dest_cap = {dest_reg[23:0], s_axis_tdata};
                default: ;
            endcase
        end
    end

    // The last byte of a frame clears the state for the next frame.
    always_comb
    begin
        if (s_axis_tlast)
        begin
            byte_count_next   = '0;
            ether_type_next   = '0;
            header_words_next = '0;
            total_length_next = '0;
            protocol_next     = '0;
            source_next       = '0;
            dest_next         = '0;
        end
        else
        begin
            byte_count_next   = count_cap;
            ether_type_next   = ether_type_cap;
            header_words_next = header_words_cap;
            total_length_next = total_length_cap;
            protocol_next     = protocol_cap;
            source_next       = source_cap;
            dest_next         = dest_cap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            ether_type_reg   <= '0;
            header_words_reg <= '0;
            total_length_reg <= '0;
            protocol_reg     <= '0;
            source_reg       <= '0;
            dest_reg         <= '0;
        end
        else if (in_fire)
        begin
            byte_count_reg   <= byte_count_next;
            ether_type_reg   <= ether_type_next;
            header_words_reg <= header_words_next;
            total_length_reg <= total_length_next;
            protocol_reg     <= protocol_next;
            source_reg       <= source_next;
            dest_reg         <= dest_next;
        end
    end

    // Verdict for a frame ending with the current byte. The IPv4 header length is
    // the IHL nibble times four; a total length shorter than the header gives a zero payload length.
    assign header_len      = {header_words_cap, 2'b00};
    assign header_len_wide = {10'd0, header_len};

    always_comb
    begin
        result.verdict        = eirc_pkg::VERDICT_SHORT;
        result.source_ip      = '0;
        result.payload_offset = '0;
        result.payload_length = '0;

        if (count_cap < eirc_pkg::ETH_HDR_LEN)
        begin
            result.verdict = eirc_pkg::VERDICT_SHORT;
        end
        else if (ether_type_cap == eirc_pkg::TYPE_ARP)
        begin
            result.verdict        = eirc_pkg::VERDICT_ARP;
            result.payload_offset = eirc_pkg::ETH_HDR_LEN[eirc_pkg::OFFSET_W-1:0];
            result.payload_length = count_cap - eirc_pkg::ETH_HDR_LEN;
        end
        else if (ether_type_cap == eirc_pkg::TYPE_IPV4)
        begin
            if (count_cap < eirc_pkg::IPV4_MIN_FRAME)
            begin
                result.verdict = eirc_pkg::VERDICT_IPV4_SHORT;
            end
            else if (addr_enabled_reg && (dest_cap != local_ip_reg) &&
                     (dest_cap != eirc_pkg::BCAST_ADDR))
            begin
                result.verdict   = eirc_pkg::VERDICT_NOT_FOR_US;
                result.source_ip = source_cap;
            end
            else
            begin
                result.source_ip      = source_cap;
                result.payload_offset = eirc_pkg::ETH_HDR_LEN[eirc_pkg::OFFSET_W-1:0]
                                        + {1'b0, header_len};
                result.payload_length = (total_length_cap >= header_len_wide) ?
                                        (total_length_cap - header_len_wide) : 16'd0;
                case (protocol_cap)
                    eirc_pkg::PROTO_ICMP: result.verdict = eirc_pkg::VERDICT_ICMP;
                    eirc_pkg::PROTO_UDP:  result.verdict = eirc_pkg::VERDICT_UDP;
                    eirc_pkg::PROTO_TCP:  result.verdict = eirc_pkg::VERDICT_TCP;
                    default:              result.verdict = eirc_pkg::VERDICT_UNKNOWN_PROT;
                endcase
            end
        end
        else
        begin
            result.verdict = eirc_pkg::VERDICT_UNKNOWN_TYPE;
        end
    end

    // Output register with a skid register behind it. A new verdict goes straight to
    // the output register when that is free or being emptied, otherwise to the skid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (produce)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (produce)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_reg <= result;
            end
            else
            begin
                skid_reg <= result;
            end
        end
    end

`ifndef SYNTH
    // The skid register is only ever filled behind a full output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a verdict while the output is empty");

    // The last byte of a frame always leaves a verdict waiting at the output.
    a_last_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> m_axis_tvalid)
        else $error("frame end accepted but no verdict presented");

    // Frame state restarts from zero after the last byte.
    a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> (byte_count_reg == '0))
        else $error("byte count not cleared after end of frame");

    // A presented verdict never carries an undefined code.
    a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:0] <= 4'd8))
        else $error("verdict code out of range");
`endif

endmodule
